[src/gcbs_pkg.sv]
// Shared types and constants of the grid cell bucket sort unit.
package gcbs_pkg;

    localparam int COORD_W = 17;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int ID_W    = 12;
    localparam int CFG_W   = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    cell_id;
        logic [ID_W-1:0]    slot;
        logic [COORD_W-1:0] x_min;
        logic [COORD_W-1:0] y_min;
        logic [COORD_W-1:0] x_max;
        logic [COORD_W-1:0] y_max;
        logic               last;
    } res_t;

endpackage

[src/gcbs_if.sv]
// Handshake channels of the grid cell bucket sort unit.
interface gcbs_req_if;
    logic                                valid;
    logic                                ready;
    logic [gcbs_pkg::CMD_W-1:0]          command;
    logic [gcbs_pkg::COORD_W-1:0]        x_min;
    logic [gcbs_pkg::COORD_W-1:0]        y_min;
    logic [gcbs_pkg::COORD_W-1:0]        x_max;
    logic [gcbs_pkg::COORD_W-1:0]        y_max;

    modport source (output valid, command, x_min, y_min, x_max, y_max, input ready);
    modport sink   (input valid, command, x_min, y_min, x_max, y_max, output ready);
endinterface

interface gcbs_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [gcbs_pkg::STAT_W-1:0]         status;
    logic [gcbs_pkg::ID_W-1:0]           cell_id;
    logic [gcbs_pkg::ID_W-1:0]           slot;
    logic [gcbs_pkg::COORD_W-1:0]        out_x_min;
    logic [gcbs_pkg::COORD_W-1:0]        out_y_min;
    logic [gcbs_pkg::COORD_W-1:0]        out_x_max;
    logic [gcbs_pkg::COORD_W-1:0]        out_y_max;
    logic                                last;

    modport source (output valid, status, cell_id, slot, out_x_min, out_y_min,
                    out_x_max, out_y_max, last, input ready);
    modport sink   (input valid, status, cell_id, slot, out_x_min, out_y_min,
                    out_x_max, out_y_max, last, output ready);
endinterface

[src/grid_cell_bucket_sort_unit.sv]
// Top level of the grid cell bucket sort unit: sequencer, shared multiplier, stores.
//
// Use: one beat on req carries a command (load, read, clear) and a rectangle; one
// beat on rsp returns its result. cfg_wr_en/cfg_wr_data set cells_per_dim; the user
// must see it written only while the block is idle; the block does not enforce it.
// req.ready is high only while the sequencer is idle. Steps per command:
//   load: the one 17 x N multiplier runs three times (x, y, row * N), then
//         one read-modify-write of the per-cell count store.
//   read: order store read, then entry store read. The first read after
//         loading first walks all cells with a prefix sum, then scatters
//         each loaded rectangle's entry into the order store.
//   clear: a sweep zeroes every cell of the count store, then the result.
//   unused command, refused load, full store: the result directly, no store access.
// Reset: the count store is zeroed by a sweep over MAX_CELLS_PER_DIM squared cells
// (4096 by default), during which req.ready stays low.
// Stall: a finished result waits in a staging register, with req.ready low, until
// rsp's output register is free; once handed over, the block takes the next beat
// while the output register still waits for rsp.ready.
module grid_cell_bucket_sort_unit #(
    parameter int MAX_RECTS         = 4096,
    parameter int MAX_CELLS_PER_DIM = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gcbs_pkg::CFG_W-1:0]    cfg_wr_data,
    gcbs_req_if.sink                      req,
    gcbs_rsp_if.source                    rsp
);
    localparam int TOTAL_CELLS = MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM;
    localparam int AW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNTW = $clog2(MAX_RECTS + 1);
    localparam int CAW  = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
    localparam int NW   = $clog2(MAX_CELLS_PER_DIM + 1);
    localparam int CW   = gcbs_pkg::COORD_W;
    localparam int PW   = CW + NW;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_MX   = 5'd2;
    localparam logic [4:0] S_MY   = 5'd3;
    localparam logic [4:0] S_MC   = 5'd4;
    localparam logic [4:0] S_LA   = 5'd5;
    localparam logic [4:0] S_LW   = 5'd6;
    localparam logic [4:0] S_PR   = 5'd7;
    localparam logic [4:0] S_PW   = 5'd8;
    localparam logic [4:0] S_S0   = 5'd9;
    localparam logic [4:0] S_S1   = 5'd10;
    localparam logic [4:0] S_S2   = 5'd11;
    localparam logic [4:0] S_RC   = 5'd12;
    localparam logic [4:0] S_RE   = 5'd13;
    localparam logic [4:0] S_RF   = 5'd14;
    localparam logic [4:0] S_EMIT = 5'd15;

    // Control state
    logic [4:0]              state_reg, state_next;
    logic [gcbs_pkg::CFG_W-1:0] cfg_reg;
    logic [CNTW-1:0]         rect_count_reg, rect_count_next;
    logic [CNTW-1:0]         rp_reg, rp_next;
    logic                    phase_reg, phase_next;
    logic                    clr_cmd_reg, clr_cmd_next;
    logic [CAW-1:0]          pidx_reg, pidx_next;
    logic [AW-1:0]           si_reg, si_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload and work registers
    logic [CW-1:0]           x_min_reg, x_min_next, y_min_reg, y_min_next;
    logic [CW-1:0]           x_max_reg, x_max_next, y_max_reg, y_max_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [NW-1:0]           cx_reg, cx_next;
    logic [CAW-1:0]          cell_reg, cell_next;
    logic [CAW-1:0]          sc_cell_reg, sc_cell_next;
    logic [CNTW-1:0]         run_reg, run_next;
    logic [PW-1:0]           prod_reg, prod_next;
    gcbs_pkg::res_t          res_reg, res_next;
    gcbs_pkg::res_t          out_reg, out_next;

    // Memory ports
    logic                    cnt_we;
    logic [CAW-1:0]          cnt_wa, cnt_ra;
    logic [CNTW-1:0]         cnt_wd, cnt_rd;
    logic                    ent_we;
    logic [AW-1:0]           ent_wa, ent_ra, cell_ra;
    logic [2*CW-1:0]         min_rd, max_rd;
    logic [CAW-1:0]          cell_rd;
    logic [AW-1:0]           slot_rd;
    logic                    ord_we;
    logic [AW-1:0]           ord_wa, ord_ra, ord_rd;

    // Shared multiplier and axis saturation
    logic [CW-1:0]           mul_a;
    logic [NW:0]             axis_q;
    logic [NW-1:0]           axis_sat;
    logic [CAW-1:0]          cell_calc;
    logic [NW-1:0]           n_calc;
    logic                    accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_MY:    mul_a = y_min_reg;
            S_MC:    mul_a = CW'(axis_sat);
            default: mul_a = x_min_reg;
        endcase
        prod_next = PW'(mul_a) * PW'(n_reg);
        axis_q    = prod_reg[PW-1:16];
        axis_sat  = (axis_q >= {1'b0, n_reg}) ? (n_reg - NW'(1)) : axis_q[NW-1:0];
        cell_calc = CAW'(prod_reg) + CAW'(cx_reg);
    end

    // Clamp the register to the supported grid size
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_calc = NW'(1);
        end
        else if (32'(cfg_reg) > MAX_CELLS_PER_DIM)
        begin
            n_calc = NW'(MAX_CELLS_PER_DIM);
        end
        else
        begin
            n_calc = NW'(cfg_reg);
        end
    end

    // Memory address and write selection
    always_comb
    begin
        case (state_reg)
            S_LA:    cnt_ra = cell_calc;
            S_PR:    cnt_ra = pidx_reg;
            S_S1:    cnt_ra = cell_rd;
            default: cnt_ra = cell_reg;
        endcase
        cnt_we = 1'b0;
        cnt_wa = pidx_reg;
        cnt_wd = '0;
        case (state_reg)
            S_CLR:
            begin
                cnt_we = 1'b1;
            end
            S_LW:
            begin
                cnt_we = 1'b1;
                cnt_wa = cell_reg;
                cnt_wd = cnt_rd + CNTW'(1);
            end
            S_PW:
            begin
                cnt_we = 1'b1;
                cnt_wd = run_reg;
            end
            S_S2:
            begin
                cnt_we = 1'b1;
                cnt_wa = sc_cell_reg;
                cnt_wd = cnt_rd + CNTW'(1);
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
        ent_we  = (state_reg == S_LW);
        ent_wa  = rect_count_reg[AW-1:0];
        ent_ra  = ord_rd;
        cell_ra = (state_reg == S_S0) ? si_reg : ord_rd;
        ord_we  = (state_reg == S_S2);
        ord_wa  = cnt_rd[AW-1:0];
        ord_ra  = rp_reg[AW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        rect_count_next = rect_count_reg;
        rp_next         = rp_reg;
        phase_next      = phase_reg;
        clr_cmd_next    = clr_cmd_reg;
        pidx_next       = pidx_reg;
        si_next         = si_reg;
        x_min_next      = x_min_reg;
        y_min_next      = y_min_reg;
        x_max_next      = x_max_reg;
        y_max_next      = y_max_reg;
        n_next          = n_reg;
        cx_next         = cx_reg;
        cell_next       = cell_reg;
        sc_cell_next    = sc_cell_reg;
        run_next        = run_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    case (req.command)
                        gcbs_pkg::CMD_LOAD:
                        begin
                            if (phase_reg)
                            begin
                                res_next.status = gcbs_pkg::STAT_REFUSED;
                                state_next      = S_EMIT;
                            end
                            else if (rect_count_reg == CNTW'(MAX_RECTS))
                            begin
                                res_next.status = gcbs_pkg::STAT_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                x_min_next = req.x_min;
                                y_min_next = req.y_min;
                                x_max_next = req.x_max;
                                y_max_next = req.y_max;
                                n_next     = n_calc;
                                state_next = S_MX;
                            end
                        end
                        gcbs_pkg::CMD_READ:
                        begin
                            if (phase_reg)
                            begin
                                state_next = S_RC;
                            end
                            else
                            begin
                                pidx_next  = '0;
                                run_next   = '0;
                                state_next = S_PR;
                            end
                        end
                        gcbs_pkg::CMD_CLEAR:
                        begin
                            rect_count_next = '0;
                            rp_next         = '0;
                            phase_next      = 1'b0;
                            pidx_next       = '0;
                            clr_cmd_next    = 1'b1;
                            state_next      = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                pidx_next = pidx_reg + CAW'(1);
                if (pidx_reg == CAW'(TOTAL_CELLS - 1))
                begin
                    pidx_next  = '0;
                    res_next   = '0;
                    state_next = clr_cmd_reg ? S_EMIT : S_IDLE;
                end
            end
            S_MX:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                cx_next    = axis_sat;
                state_next = S_MC;
            end
            S_MC:
            begin
                state_next = S_LA;
            end
            S_LA:
            begin
                cell_next  = cell_calc;
                state_next = S_LW;
            end
            S_LW:
            begin
                // Count read back: it is this rectangle's slot
                res_next.status  = gcbs_pkg::STAT_OK;
                res_next.cell_id = gcbs_pkg::ID_W'(cell_reg);
                res_next.slot    = gcbs_pkg::ID_W'(cnt_rd);
                res_next.x_min   = x_min_reg;
                res_next.y_min   = y_min_reg;
                res_next.x_max   = x_max_reg;
                res_next.y_max   = y_max_reg;
                res_next.last    = 1'b0;
                rect_count_next  = rect_count_reg + CNTW'(1);
                state_next       = S_EMIT;
            end
            S_PR:
            begin
                state_next = S_PW;
            end
            S_PW:
            begin
                run_next  = run_reg + cnt_rd;
                pidx_next = pidx_reg + CAW'(1);
                if (pidx_reg == CAW'(TOTAL_CELLS - 1))
                begin
                    pidx_next = '0;
                    si_next   = '0;
                    if (rect_count_reg == '0)
                    begin
                        phase_next = 1'b1;
                        rp_next    = '0;
                        state_next = S_RC;
                    end
                    else
                    begin
                        state_next = S_S0;
                    end
                end
                else
                begin
                    state_next = S_PR;
                end
            end
            S_S0:
            begin
                state_next = S_S1;
            end
            S_S1:
            begin
                sc_cell_next = cell_rd;
                state_next   = S_S2;
            end
            S_S2:
            begin
                if (CNTW'(si_reg) + CNTW'(1) == rect_count_reg)
                begin
                    phase_next = 1'b1;
                    rp_next    = '0;
                    state_next = S_RC;
                end
                else
                begin
                    si_next    = si_reg + AW'(1);
                    state_next = S_S0;
                end
            end
            S_RC:
            begin
                if (rp_reg >= rect_count_reg)
                begin
                    res_next        = '0;
                    res_next.status = gcbs_pkg::STAT_EMPTY;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_RE;
                end
            end
            S_RE:
            begin
                state_next = S_RF;
            end
            S_RF:
            begin
                res_next.status  = gcbs_pkg::STAT_OK;
                res_next.cell_id = gcbs_pkg::ID_W'(cell_rd);
                res_next.slot    = gcbs_pkg::ID_W'(slot_rd);
                res_next.x_min   = min_rd[CW-1:0];
                res_next.y_min   = min_rd[2*CW-1:CW];
                res_next.x_max   = max_rd[CW-1:0];
                res_next.y_max   = max_rd[2*CW-1:CW];
                res_next.last    = (rp_reg + CNTW'(1) == rect_count_reg);
                rp_next          = rp_reg + CNTW'(1);
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cfg_reg        <= gcbs_pkg::CFG_RESET;
            rect_count_reg <= '0;
            rp_reg         <= '0;
            phase_reg      <= 1'b0;
            clr_cmd_reg    <= 1'b0;
            pidx_reg       <= '0;
            si_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            rect_count_reg <= rect_count_next;
            rp_reg         <= rp_next;
            phase_reg      <= phase_next;
            clr_cmd_reg    <= clr_cmd_next;
            pidx_reg       <= pidx_next;
            si_reg         <= si_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_min_reg   <= x_min_next;
        y_min_reg   <= y_min_next;
        x_max_reg   <= x_max_next;
        y_max_reg   <= y_max_next;
        n_reg       <= n_next;
        cx_reg      <= cx_next;
        cell_reg    <= cell_next;
        sc_cell_reg <= sc_cell_next;
        run_reg     <= run_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // Stores
    gcbs_ram #(.WIDTH(CNTW), .DEPTH(TOTAL_CELLS)) u_cnt_ram (
        .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
        .rd_addr(cnt_ra), .rd_data(cnt_rd)
    );
    gcbs_ram #(.WIDTH(2*CW), .DEPTH(MAX_RECTS)) u_min_ram (
        .clk(clk), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data({y_min_reg, x_min_reg}),
        .rd_addr(ent_ra), .rd_data(min_rd)
    );
    gcbs_ram #(.WIDTH(2*CW), .DEPTH(MAX_RECTS)) u_max_ram (
        .clk(clk), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data({y_max_reg, x_max_reg}),
        .rd_addr(ent_ra), .rd_data(max_rd)
    );
    gcbs_ram #(.WIDTH(CAW), .DEPTH(MAX_RECTS)) u_cell_ram (
        .clk(clk), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(cell_reg),
        .rd_addr(cell_ra), .rd_data(cell_rd)
    );
    gcbs_ram #(.WIDTH(AW), .DEPTH(MAX_RECTS)) u_slot_ram (
        .clk(clk), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(cnt_rd[AW-1:0]),
        .rd_addr(ent_ra), .rd_data(slot_rd)
    );
    gcbs_ram #(.WIDTH(AW), .DEPTH(MAX_RECTS)) u_ord_ram (
        .clk(clk), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(si_reg),
        .rd_addr(ord_ra), .rd_data(ord_rd)
    );

    // Drive the result channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.cell_id   = out_reg.cell_id;
    assign rsp.slot      = out_reg.slot;
    assign rsp.out_x_min = out_reg.x_min;
    assign rsp.out_y_min = out_reg.y_min;
    assign rsp.out_x_max = out_reg.x_max;
    assign rsp.out_y_max = out_reg.y_max;
    assign rsp.last      = out_reg.last;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rect_count_reg <= CNTW'(MAX_RECTS))
        else $error("rectangle count above capacity");
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> rp_reg <= rect_count_reg)
        else $error("read pointer past loaded rectangles");
    a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !req.ready)
        else $error("input taken during clearing sweep");
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.last |-> rsp.status == gcbs_pkg::STAT_OK)
        else $error("last flag on a failed result");
    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LW |-> !phase_reg)
        else $error("store written after reading began");
endmodule

[src/gcbs_ram.sv]
// Generic one-write, one-read RAM with registered read data.
module gcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, then registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[bench/grid_cell_bucket_sort_unit_tb.sv]
// Self-checking testbench for the grid cell bucket sort unit.
module grid_cell_bucket_sort_unit_tb;

    localparam int NRECT  = 4096;
    localparam int NCELLS = 4096;
    localparam int DRAIN  = 9000;
    localparam int CW     = gcbs_pkg::COORD_W;
    localparam int GW     = gcbs_pkg::CFG_W;
    localparam int IW     = gcbs_pkg::ID_W;
    localparam int MW     = gcbs_pkg::CMD_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [GW-1:0] cfg_wr_data = '0;

    gcbs_req_if req ();
    gcbs_rsp_if rsp ();

    grid_cell_bucket_sort_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .req(req.sink), .rsp(rsp.source)
    );

    always #6 clk = ~clk;

    // Shadow state of the sorter
    logic [GW-1:0]      grid_reg;
    logic [CW-1:0]      sh_xmin [NRECT];
    logic [CW-1:0]      sh_ymin [NRECT];
    logic [CW-1:0]      sh_xmax [NRECT];
    logic [CW-1:0]      sh_ymax [NRECT];
    int unsigned        sh_cell [NRECT];
    int unsigned        sh_slot [NRECT];
    int unsigned        cell_tally [NCELLS];
    int unsigned        sorted_idx [NRECT];
    int unsigned        n_stored;
    int unsigned        rd_ptr;
    bit                 draining;

    gcbs_pkg::res_t expected_rsp [$];
    int   errors = 0;
    int   beats_out = 0;
    int   loads_sent = 0;
    int   reads_sent = 0;

    function automatic int unsigned axis_of(logic [CW-1:0] c, int unsigned n);
        int unsigned v;
        v = (c * n) >> 16;
        return (v >= n) ? n - 1 : v;
    endfunction

    // Build stable counting-sort order over all cells
    function automatic void build_sorted();
        int unsigned run;
        int unsigned fill [NCELLS];
        run = 0;
        for (int i = 0; i < NCELLS; i++)
        begin
            fill[i] = run;
            run += cell_tally[i];
        end
        for (int i = 0; i < n_stored; i++)
        begin
            sorted_idx[fill[sh_cell[i]]] = i;
            fill[sh_cell[i]]++;
        end
    endfunction

    // Compute the result of one command and advance the shadow state
    function automatic gcbs_pkg::res_t sort_predict(logic [MW-1:0] cmd, logic [CW-1:0] xa,
                                                    logic [CW-1:0] ya, logic [CW-1:0] xb,
                                                    logic [CW-1:0] yb);
        gcbs_pkg::res_t r;
        int unsigned n, c, e;
        r = '0;
        if (cmd == gcbs_pkg::CMD_LOAD)
        begin
            if (draining)
                r.status = gcbs_pkg::STAT_REFUSED;
            else if (n_stored >= NRECT)
                r.status = gcbs_pkg::STAT_FULL;
            else
            begin
                n = (grid_reg == 0) ? 1 : (grid_reg > 64) ? 64 : grid_reg;
                c = (axis_of(ya, n) * n + axis_of(xa, n)) % NCELLS;
                sh_xmin[n_stored] = xa;
                sh_ymin[n_stored] = ya;
                sh_xmax[n_stored] = xb;
                sh_ymax[n_stored] = yb;
                sh_cell[n_stored] = c;
                sh_slot[n_stored] = cell_tally[c];
                cell_tally[c]++;
                r.cell_id = c[IW-1:0];
                r.slot = sh_slot[n_stored][IW-1:0];
                r.x_min = xa;
                r.y_min = ya;
                r.x_max = xb;
                r.y_max = yb;
                n_stored++;
            end
        end
        else if (cmd == gcbs_pkg::CMD_READ)
        begin
            if (!draining)
            begin
                build_sorted();
                draining = 1'b1;
                rd_ptr = 0;
            end
            if (rd_ptr >= n_stored)
                r.status = gcbs_pkg::STAT_EMPTY;
            else
            begin
                e = sorted_idx[rd_ptr];
                r.cell_id = sh_cell[e][IW-1:0];
                r.slot = sh_slot[e][IW-1:0];
                r.x_min = sh_xmin[e];
                r.y_min = sh_ymin[e];
                r.x_max = sh_xmax[e];
                r.y_max = sh_ymax[e];
                rd_ptr++;
                r.last = (rd_ptr == n_stored);
            end
        end
        else if (cmd == gcbs_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < NCELLS; i++)
                cell_tally[i] = 0;
            n_stored = 0;
            rd_ptr = 0;
            draining = 1'b0;
        end
        return r;
    endfunction

    // Send one beat and queue its expected result; valid stays up for a back-to-back beat
    task automatic send_cmd(logic [MW-1:0] cmd, logic [CW-1:0] xa,
                            logic [CW-1:0] ya, logic [CW-1:0] xb,
                            logic [CW-1:0] yb);
        int gap;
        gcbs_pkg::res_t exp_item;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.x_min <= xa;
        req.y_min <= ya;
        req.x_max <= xb;
        req.y_max <= yb;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        exp_item = sort_predict(cmd, xa, ya, xb, yb);
        expected_rsp.insert(expected_rsp.size(), exp_item);
        if (cmd == gcbs_pkg::CMD_LOAD) loads_sent++;
        if (cmd == gcbs_pkg::CMD_READ) reads_sent++;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF - CW'($urandom_range(0, 3));
            3: return CW'($urandom_range(65536, 131071));
            default: return CW'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic load_rand();
        send_cmd(gcbs_pkg::CMD_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Drop valid, wait for outstanding results, then for the block to go idle
    task automatic settle();
        req.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_grid(logic [GW-1:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        grid_reg = v;
    endtask

    // Check each result beat against the oldest expectation
    initial
    begin
        gcbs_pkg::res_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                beats_out++;
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual status %0d cell %0d",
                             $time, rsp.status, rsp.cell_id);
                    errors++;
                end
                else
                begin
                    exp_r = expected_rsp.pop_front();
                    if (rsp.status !== exp_r.status || rsp.cell_id !== exp_r.cell_id ||
                        rsp.slot !== exp_r.slot || rsp.out_x_min !== exp_r.x_min ||
                        rsp.out_y_min !== exp_r.y_min || rsp.out_x_max !== exp_r.x_max ||
                        rsp.out_y_max !== exp_r.y_max || rsp.last !== exp_r.last)
                    begin
                        $display("%0t: mismatch expected st=%0d id=%0d sl=%0d %0h %0h %0h %0h l=%0b",
                                 $time, exp_r.status, exp_r.cell_id, exp_r.slot, exp_r.x_min,
                                 exp_r.y_min, exp_r.x_max, exp_r.y_max, exp_r.last);
                        $display("%0t:          actual   st=%0d id=%0d sl=%0d %0h %0h %0h %0h l=%0b",
                                 $time, rsp.status, rsp.cell_id, rsp.slot, rsp.out_x_min,
                                 rsp.out_y_min, rsp.out_x_max, rsp.out_y_max, rsp.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Stall the result side: random holds, with calm stretches
    initial
    begin
        int hold;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 9) < 2)
                rsp.ready <= 1'b1;
            else
            begin
                hold = $urandom_range(0, 5);
                rsp.ready <= (hold == 0);
                if (hold != 0)
                begin
                    repeat (hold) @(posedge clk);
                    rsp.ready <= 1'b1;
                end
            end
        end
    end

    task automatic test_directed();
        send_cmd(gcbs_pkg::CMD_READ, '0, '0, '0, '0);
        send_cmd(gcbs_pkg::CMD_LOAD, '0, '0, '0, '0);
        send_cmd(gcbs_pkg::CMD_CLEAR, '0, '0, '0, '0);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'd0, 17'd0, 17'h1FFFF, 17'h1FFFF);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'h1FFFF, 17'd0, 17'h15555, 17'h0AAAA);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'd65535, 17'd4095, 17'h0AAAA, 17'h15555);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'd0, 17'd0, 17'd1, 17'd2);
        send_cmd(gcbs_pkg::CMD_NOP, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        repeat (6) send_cmd(gcbs_pkg::CMD_READ, '0, '0, '0, '0);
        send_cmd(gcbs_pkg::CMD_LOAD, 17'd5, 17'd5, 17'd5, 17'd5);
        send_cmd(gcbs_pkg::CMD_CLEAR, '0, '0, '0, '0);
    endtask

    // Cell changes mid-load: each rectangle keeps its original cell
    task automatic test_regrid();
        write_grid(7'd0);
        repeat (3) load_rand();
        write_grid(7'd127);
        repeat (3) load_rand();
        write_grid(7'd64);
        repeat (3) load_rand();
        send_cmd(gcbs_pkg::CMD_READ, '0, '0, '0, '0);
        repeat (9) send_cmd(gcbs_pkg::CMD_READ, '0, '0, '0, '0);
        send_cmd(gcbs_pkg::CMD_CLEAR, '0, '0, '0, '0);
    endtask

    // Mostly load-then-drain batches, with some noise commands mixed in
    task automatic test_random(int target);
        int k, done_items;
        logic [GW-1:0] sizes [6];
        sizes = '{7'd1, 7'd2, 7'd16, 7'd64, 7'd100, 7'd0};
        done_items = 0;
        while (done_items < target)
        begin
            write_grid($urandom_range(0, 3) == 0 ? sizes[$urandom_range(0, 5)]
                                                 : GW'($urandom_range(1, 64)));
            k = $urandom_range(1, 40);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_cmd(gcbs_pkg::CMD_NOP, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord());
                else
                    load_rand();
            end
            for (int i = 0; i < k + $urandom_range(0, 2); i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    load_rand();
                else
                    send_cmd(gcbs_pkg::CMD_READ, '0, '0, '0, '0);
            end
            send_cmd(gcbs_pkg::CMD_CLEAR, '0, '0, '0, '0);
            done_items += 2 * k + 1;
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.command = gcbs_pkg::CMD_LOAD;
        req.x_min = '0;
        req.y_min = '0;
        req.x_max = '0;
        req.y_max = '0;
        grid_reg = gcbs_pkg::CFG_RESET;
        n_stored = 0;
        rd_ptr = 0;
        draining = 1'b0;
        for (int i = 0; i < NCELLS; i++)
            cell_tally[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_regrid();
        test_random(1400);
        settle();
        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d loads and %0d reads, %0d result beats checked.",
                 loads_sent, reads_sent, beats_out);
        $display("Grids from 0 to 127 cells per axis, refused loads and unused commands.");
        if (errors == 0 && expected_rsp.size() == 0)
            $display("grid_cell_bucket_sort_unit_tb: done, clean");
        else
            $display("grid_cell_bucket_sort_unit_tb: done, errors");
        $finish;
    end

    // Timeout guard
    initial
    begin
        #40000000;
        $display("grid_cell_bucket_sort_unit_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
src/gcbs_pkg.sv
src/gcbs_if.sv
src/gcbs_ram.sv
src/grid_cell_bucket_sort_unit.sv
bench/grid_cell_bucket_sort_unit_tb.sv
